### src/gbn_pkg.sv
package gbn_pkg;

  // default widths
  localparam int unsigned SeqBitsDefault    = 24;
  localparam int unsigned WindowBitsDefault = 16;

  // send credit is a fixed 17-bit saturating counter
  localparam int unsigned CreditBits   = 17;
  localparam int unsigned CredSumBits  = CreditBits + 1;

  // register reset values
  localparam int unsigned TotalChunksReset = 0;
  localparam int unsigned InitWindowReset  = 3;
  localparam int unsigned MaxWindowReset   = 1000;
  localparam int unsigned MinWindowReset   = 2;

  typedef enum logic [1:0] {
    CmdAck     = 2'd0,
    CmdTimeout = 2'd1,
    CmdSlot    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RegTotalChunks   = 2'd0,
    RegInitialWindow = 2'd1,
    RegMaxWindow     = 2'd2,
    RegMinWindow     = 2'd3
  } cfg_reg_e;

  // per-event status bits
  typedef struct packed {
    logic sent;
    logic ended;
    logic complete;
  } step_flags_t;

endpackage

### src/gbn_step.sv
module gbn_step #(
  parameter int unsigned SEQ_BITS    = gbn_pkg::SeqBitsDefault,
  parameter int unsigned WINDOW_BITS = gbn_pkg::WindowBitsDefault
) (
  input  logic [1:0]                   cmd_i,
  input  logic [SEQ_BITS-1:0]          ack_i,
  input  logic [SEQ_BITS-1:0]          total_i,
  input  logic [WINDOW_BITS-1:0]       max_win_i,
  input  logic [WINDOW_BITS-1:0]       min_win_i,
  input  logic [SEQ_BITS-1:0]          ha_q_i,
  input  logic [SEQ_BITS-1:0]          ns_q_i,
  input  logic [WINDOW_BITS-1:0]       win_q_i,
  input  logic [gbn_pkg::CreditBits-1:0] cred_q_i,
  input  logic                         fill_q_i,
  output logic [SEQ_BITS-1:0]          ha_d_o,
  output logic [SEQ_BITS-1:0]          ns_d_o,
  output logic [WINDOW_BITS-1:0]       win_d_o,
  output logic [gbn_pkg::CreditBits-1:0] cred_d_o,
  output logic                         fill_d_o,
  output logic [SEQ_BITS-1:0]          send_seq_o,
  output gbn_pkg::step_flags_t         flags_o
);
  import gbn_pkg::*;

  localparam int unsigned CmpBits = (SEQ_BITS > WINDOW_BITS) ? SEQ_BITS : WINDOW_BITS;

  logic [SEQ_BITS-1:0]    ha, ns, seq, j;
  logic [WINDOW_BITS-1:0] win, room, g, half;
  logic [CreditBits-1:0]  cred;
  logic [CredSumBits-1:0] cred_sum;
  logic                   fill, sent, ended;

  // in-flight count below window
  function automatic logic has_room(input logic [SEQ_BITS-1:0] n,
                                    input logic [SEQ_BITS-1:0] h,
                                    input logic [WINDOW_BITS-1:0] w);
    logic [SEQ_BITS-1:0] infl;
    infl = (n > h) ? (n - h) : '0;
    return CmpBits'(infl) < CmpBits'(w);
  endfunction

  always_comb begin
    ha       = ha_q_i;
    ns       = ns_q_i;
    win      = win_q_i;
    cred     = cred_q_i;
    fill     = fill_q_i;
    sent     = 1'b0;
    ended    = 1'b0;
    seq      = '0;
    j        = '0;
    room     = '0;
    g        = '0;
    cred_sum = '0;
    half     = '0;

    case (cmd_i)
      CmdAck: begin
        if (ack_i > ha) begin
          j  = ack_i - ha;
          ha = ack_i;
          if (win >= max_win_i) begin
            win = max_win_i;
          end else begin
            room     = max_win_i - win;
            g        = (CmpBits'(j) > CmpBits'(room)) ? room : WINDOW_BITS'(j);
            win      = win + g;
            cred_sum = {1'b0, cred} + CredSumBits'({g, 1'b0});
            cred     = cred_sum[CreditBits] ? '1 : cred_sum[CreditBits-1:0];
          end
        end
      end
      CmdTimeout: begin
        if (ha < total_i) begin
          ended = 1'b1;
        end
      end
      CmdSlot: begin
        if (ha < total_i && ns < total_i) begin
          if (fill) begin
            sent = has_room(ns, ha, win);
          end else if (cred != '0) begin
            cred = cred - CreditBits'(1);
            sent = 1'b1;
          end
          if (sent) begin
            seq = ns;
            ns  = ns + SEQ_BITS'(1);
          end
        end
      end
      default: ;
    endcase

    // fill phase exit, then round-end check
    if (!ended) begin
      if (fill && ha < total_i) begin
        if (!(has_room(ns, ha, win) && ns < total_i)) begin
          fill = 1'b0;
        end
      end
      if (!fill && ha >= ns && (cred == '0 || ns >= total_i)) begin
        ended = 1'b1;
      end
    end

    // halve window within min/max, clear credit, rewind to the ack, restart fill
    if (ended) begin
      half = win >> 1;
      if (half < min_win_i) half = min_win_i;
      if (half > max_win_i) half = max_win_i;
      win  = half;
      cred = '0;
      ns   = ha;
      fill = 1'b1;
    end

    ha_d_o           = ha;
    ns_d_o           = ns;
    win_d_o          = win;
    cred_d_o         = cred;
    fill_d_o         = fill;
    send_seq_o       = seq;
    flags_o.sent     = sent;
    flags_o.ended    = ended;
    flags_o.complete = (ha >= total_i);
  end

endmodule

### src/go_back_n_window_sender_top.sv
// Go-back-N sender control with an additive-increase / halving congestion
// window. Each input beat is one event (ack, timeout or offered send slot)
// and gives exactly one result beat: whether a chunk goes out and its
// sequence number, whether a round ended, the window after the event and
// whether everything is acked. One event is taken every cycle while
// in_stall_o is low: the whole state update is one combinational pass
// of the step logic between the state registers, so the next event
// sees the new state right away. Each result is registered in the
// result register, or in a one-beat skid register when that one is
// stalled, so input keeps flowing for one beat while the result is
// stalled; in_stall_o rises only when both hold a beat. Configuration
// writes are always ready and act at once; a write of initial_window is
// accepted but ignored, as only reset seeds the window from its default.
module go_back_n_window_sender_top #(
  parameter int unsigned SEQ_BITS    = gbn_pkg::SeqBitsDefault,
  parameter int unsigned WINDOW_BITS = gbn_pkg::WindowBitsDefault,
  localparam int unsigned CFG_BITS   = (SEQ_BITS > WINDOW_BITS) ? SEQ_BITS : WINDOW_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [CFG_BITS-1:0]    cfg_data_i,
  // event channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             command_i,
  input  logic [SEQ_BITS-1:0]    ack_number_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   send_valid_o,
  output logic [SEQ_BITS-1:0]    send_sequence_o,
  output logic                   round_ended_o,
  output logic [WINDOW_BITS-1:0] window_now_o,
  output logic                   all_acked_o
);
  import gbn_pkg::*;

  // configuration registers
  logic [SEQ_BITS-1:0]    total_q;
  logic [WINDOW_BITS-1:0] max_win_q, min_win_q;

  // sender state
  logic [SEQ_BITS-1:0]    ha_q, ha_d;
  logic [SEQ_BITS-1:0]    ns_q, ns_d;
  logic [WINDOW_BITS-1:0] win_q, win_d;
  logic [CreditBits-1:0]  cred_q, cred_d;
  logic                   fill_q, fill_d;

  // step results
  logic [SEQ_BITS-1:0]    send_seq;
  step_flags_t            flags;

  // result register and skid register
  logic                   out_valid_q, skid_valid_q;
  logic [SEQ_BITS-1:0]    out_seq_q, skid_seq_q;
  logic [WINDOW_BITS-1:0] out_win_q, skid_win_q;
  step_flags_t            out_flags_q, skid_flags_q;

  logic in_fire, out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;

  // config writes, unused high data bits dropped per register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= SEQ_BITS'(TotalChunksReset);
      max_win_q <= WINDOW_BITS'(MaxWindowReset);
      min_win_q <= WINDOW_BITS'(MinWindowReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegTotalChunks:   total_q   <= cfg_data_i[SEQ_BITS-1:0];
        RegInitialWindow: ;  // only the reset default seeds the window
        RegMaxWindow:     max_win_q <= cfg_data_i[WINDOW_BITS-1:0];
        RegMinWindow:     min_win_q <= cfg_data_i[WINDOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  gbn_step #(
    .SEQ_BITS    (SEQ_BITS),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_step (
    .cmd_i      (command_i),
    .ack_i      (ack_number_i),
    .total_i    (total_q),
    .max_win_i  (max_win_q),
    .min_win_i  (min_win_q),
    .ha_q_i     (ha_q),
    .ns_q_i     (ns_q),
    .win_q_i    (win_q),
    .cred_q_i   (cred_q),
    .fill_q_i   (fill_q),
    .ha_d_o     (ha_d),
    .ns_d_o     (ns_d),
    .win_d_o    (win_d),
    .cred_d_o   (cred_d),
    .fill_d_o   (fill_d),
    .send_seq_o (send_seq),
    .flags_o    (flags)
  );

  // state advances on every accepted event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ha_q   <= '0;
      ns_q   <= '0;
      win_q  <= WINDOW_BITS'(InitWindowReset);
      cred_q <= '0;
      fill_q <= 1'b1;
    end else if (in_fire) begin
      ha_q   <= ha_d;
      ns_q   <= ns_d;
      win_q  <= win_d;
      cred_q <= cred_d;
      fill_q <= fill_d;
    end
  end

  // output control: the skid register catches a beat when the result is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_seq_q   <= skid_seq_q;
        out_win_q   <= skid_win_q;
        out_flags_q <= skid_flags_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_seq_q   <= send_seq;
        out_win_q   <= win_d;
        out_flags_q <= flags;
      end else begin
        skid_seq_q   <= send_seq;
        skid_win_q   <= win_d;
        skid_flags_q <= flags;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_valid_o    = out_flags_q.sent;
  assign send_sequence_o = out_seq_q;
  assign round_ended_o   = out_flags_q.ended;
  assign window_now_o    = out_win_q;
  assign all_acked_o     = out_flags_q.complete;

  // skid only ever holds a beat behind a full result register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while result register empty");

  // a round end clears credit and rewinds sending to the ack
  a_round_end_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && flags.ended) |=> (cred_q == '0 && fill_q && ns_q == ha_q))
    else $error("round end did not rewind sender state");

  // nothing is sent once everything is acked
  a_no_send_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && ha_q >= total_q) |-> !flags.sent)
    else $error("chunk sent after transfer complete");

  // a send emits the current next sequence
  a_send_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && flags.sent) |-> (send_seq == ns_q))
    else $error("sent sequence differs from next sequence");

endmodule
